/* hdl/dqb_pkg.sv */
// ----------------------------------------------------------------------------
// dqb_pkg
// Shared types, constants and byte tables for the DNS query builder.
// ----------------------------------------------------------------------------
package dqb_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [3:0] step_t;

  localparam byte_t DOT_CHAR = 8'h2E;
  localparam step_t HDR_LAST = 4'd11;
  localparam step_t TRL_LAST = 4'd4;

  // 12-byte header: id high first, flags 0x0100, QDCOUNT 1, other counts 0
  function automatic byte_t hdr_byte(input step_t idx, input logic [15:0] id);
    byte_t b;
    unique case (idx)
      4'd0:    b = id[15:8];
      4'd1:    b = id[7:0];
      4'd2:    b = 8'h01;
      4'd5:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  // root byte, QTYPE A, QCLASS IN
  function automatic byte_t trl_byte(input step_t idx);
    byte_t b;
    unique case (idx)
      4'd2:    b = 8'h01;
      4'd4:    b = 8'h01;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

/* hdl/dqb_if.sv */
// ----------------------------------------------------------------------------
// dqb_in_if / dqb_out_if
// Valid/ready channels for host name bytes in and query message bytes out.
// ----------------------------------------------------------------------------
interface dqb_in_if;
  import dqb_pkg::*;

  logic        valid;
  logic        ready;
  byte_t       name_byte;
  logic        name_end;
  logic [15:0] query_id;

  modport source (output valid, name_byte, name_end, query_id, input ready);
  modport sink   (input valid, name_byte, name_end, query_id, output ready);
endinterface

interface dqb_out_if;
  import dqb_pkg::*;

  logic  valid;
  logic  ready;
  byte_t packet_byte;
  logic  packet_end;
  logic  run_end;
  logic  label_overflow;

  modport source (output valid, packet_byte, packet_end, run_end, label_overflow,
                  input ready);
  modport sink   (input valid, packet_byte, packet_end, run_end, label_overflow,
                  output ready);
endinterface

/* hdl/dqb_label_mem.sv */
// ----------------------------------------------------------------------------
// dqb_label_mem
// Label buffer: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module dqb_label_mem #(
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  dqb_pkg::byte_t    wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output dqb_pkg::byte_t    rd_data
);
  import dqb_pkg::*;

  byte_t mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data while no read is issued
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* hdl/dns_query_builder.sv */
// ----------------------------------------------------------------------------
// dns_query_builder
// Forms a DNS standard query (type A, class IN) from a dotted host name.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan carries one host name character per beat, with name_end on the
//   last one; query_id is sampled on the first character of each name.
//   out_chan carries the query message one byte per beat: packet_end flags
//   the final byte, run_end the last byte caused by one input beat, and
//   label_overflow the length and data bytes of a label cut to MAX_LABEL.
//   Label characters are written into a label buffer memory as they arrive
//   and read back when a dot or name_end closes the label.
// Throughput:
//   A beat that emits nothing leaves in_chan ready for the next beat. A beat
//   that emits bytes, with the sink ready, moves one output byte per cycle,
//   set by the single output register and the buffer's one read port. The
//   beat moves the sequencer to an emitting state, which loads the output register.
// Reset and stall:
//   Synchronous active-low reset returns to waiting for a name's first
//   character; the buffer contents are not cleared. A stalled sink holds the
//   output register and the sequencer; in_chan.ready stays low until all
//   bytes of the current beat have moved into the output register.
// ----------------------------------------------------------------------------
module dns_query_builder #(
  parameter int MAX_LABEL = 32
) (
  input logic       clk,
  input logic       rst_n,
  dqb_in_if.sink    in_chan,
  dqb_out_if.source out_chan
);
  import dqb_pkg::*;

  localparam int CNT_W = $clog2(MAX_LABEL + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LABEL);

  typedef enum logic [2:0] {ST_IDLE, ST_HDR, ST_LEN, ST_DATA, ST_TRL} state_t;

  state_t           state_r;
  logic             inside_r;
  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;
  step_t            step_r;
  logic [CNT_W-1:0] idx_r;
  logic [CNT_W-1:0] flen_r;
  logic             fovf_r;
  logic             do_flush_r;
  logic             do_trl_r;
  logic [15:0]      id_r;
  logic             out_valid_r;
  byte_t            out_byte_r;
  logic             out_pend_r;
  logic             out_run_r;
  logic             out_ovf_r;

  logic             acc;
  logic             emit;
  logic             out_load;
  logic             out_valid_nxt;
  logic             is_dot;
  logic             flush;
  logic [CNT_W-1:0] cnt_base;
  logic             ovf_base;
  logic             fits;
  logic             wr_en;
  logic [CNT_W-1:0] cnt_add;
  logic             ovf_add;
  logic [CNT_W-1:0] cnt_nxt;
  logic             ovf_nxt;
  logic             do_flush;
  state_t           first_st;
  logic [CNT_W-1:0] idx_inc;
  logic             data_last;
  logic             rd_en;
  logic [CNT_W-1:0] rd_addr;
  byte_t            rd_data;

  assign in_chan.ready           = (state_r == ST_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.packet_byte    = out_byte_r;
  assign out_chan.packet_end     = out_pend_r;
  assign out_chan.run_end        = out_run_r;
  assign out_chan.label_overflow = out_ovf_r;

  assign acc  = in_chan.valid && in_chan.ready;
  assign emit = !out_valid_r || out_chan.ready;

  // load the output register from any emitting state, else hold until taken
  assign out_load      = emit && (state_r == ST_HDR || state_r == ST_LEN ||
                                  state_r == ST_DATA || state_r == ST_TRL);
  assign out_valid_nxt = out_load || (out_valid_r && !out_chan.ready);

  // label state as seen by this beat; a new name starts empty
  always_comb begin
    cnt_base = inside_r ? cnt_r : '0;
    ovf_base = inside_r && ovf_r;
    is_dot   = (in_chan.name_byte == DOT_CHAR);
    fits     = (cnt_base < MAX_CNT);
    wr_en    = acc && !is_dot && fits;
    cnt_add  = (!is_dot && fits) ? CNT_W'(cnt_base + 1'b1) : cnt_base;
    ovf_add  = ovf_base || (!is_dot && !fits);
    flush    = is_dot || in_chan.name_end;
    do_flush = flush && (cnt_add != '0);
    cnt_nxt  = flush ? '0 : cnt_add;
    ovf_nxt  = flush ? 1'b0 : ovf_add;
    priority if (!inside_r) begin
      first_st = ST_HDR;
    end else if (do_flush) begin
      first_st = ST_LEN;
    end else if (in_chan.name_end) begin
      first_st = ST_TRL;
    end else begin
      first_st = ST_IDLE;
    end
  end

  assign idx_inc   = CNT_W'(idx_r + 1'b1);
  assign data_last = (idx_inc == flen_r);

  // prefetch the next label byte whenever one leaves for the output register
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = idx_inc;
    if (state_r == ST_LEN && emit) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end else if (state_r == ST_DATA && emit) begin
      rd_en = 1'b1;
    end
  end

  dqb_label_mem #(
    .ADDR_W (CNT_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cnt_base),
    .wr_data (in_chan.name_byte),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      inside_r    <= 1'b0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (acc) begin
            inside_r   <= !in_chan.name_end;
            cnt_r      <= cnt_nxt;
            ovf_r      <= ovf_nxt;
            id_r       <= in_chan.query_id;
            flen_r     <= cnt_add;
            fovf_r     <= ovf_add;
            do_flush_r <= do_flush;
            do_trl_r   <= in_chan.name_end;
            step_r     <= '0;
            state_r    <= first_st;
          end
        end
        ST_HDR: begin
          if (emit) begin
            out_byte_r  <= hdr_byte(step_r, id_r);
            out_pend_r  <= 1'b0;
            out_run_r   <= (step_r == HDR_LAST) && !do_flush_r && !do_trl_r;
            out_ovf_r   <= 1'b0;
            if (step_r == HDR_LAST) begin
              step_r <= '0;
              priority if (do_flush_r) begin
                state_r <= ST_LEN;
              end else if (do_trl_r) begin
                state_r <= ST_TRL;
              end else begin
                state_r <= ST_IDLE;
              end
            end else begin
              step_r <= step_t'(step_r + 1'b1);
            end
          end
        end
        ST_LEN: begin
          if (emit) begin
            out_byte_r  <= byte_t'(flen_r);
            out_pend_r  <= 1'b0;
            out_run_r   <= 1'b0;
            out_ovf_r   <= fovf_r;
            idx_r       <= '0;
            state_r     <= ST_DATA;
          end
        end
        ST_DATA: begin
          if (emit) begin
            out_byte_r  <= rd_data;
            out_pend_r  <= 1'b0;
            out_run_r   <= data_last && !do_trl_r;
            out_ovf_r   <= fovf_r;
            if (data_last) begin
              step_r  <= '0;
              state_r <= do_trl_r ? ST_TRL : ST_IDLE;
            end else begin
              idx_r <= idx_inc;
            end
          end
        end
        ST_TRL: begin
          if (emit) begin
            out_byte_r  <= trl_byte(step_r);
            out_pend_r  <= (step_r == TRL_LAST);
            out_run_r   <= (step_r == TRL_LAST);
            out_ovf_r   <= 1'b0;
            if (step_r == TRL_LAST) begin
              state_r <= ST_IDLE;
            end else begin
              step_r <= step_t'(step_r + 1'b1);
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

/* tb/sv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for dns_query_builder: drives host names one character
// per beat and compares every query message byte with a local prediction.
// ----------------------------------------------------------------------------
module tb;
  import dqb_pkg::*;

  localparam int LABEL_MAX    = 32;
  localparam int ITEM_GOAL    = 450;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 64;
  localparam int SHOWN_MAX    = 10;

  // flags 0x0100, QDCOUNT 1, AN/NS/AR counts 0
  localparam logic [79:0] HDR_TAIL = 80'h0100_0001_0000_0000_0000;
  // root, QTYPE A, QCLASS IN
  localparam logic [39:0] QUESTION_TAIL = 40'h00_0001_0001;

  typedef struct packed {
    byte_t data;
    logic  msg_end;
    logic  beat_last;
    logic  cut;
  } msg_byte_t;

  logic clk = 1'b0;
  logic rst_n;

  always #10 clk = ~clk;

  dqb_in_if  name_if ();
  dqb_out_if msg_if ();

  dns_query_builder #(.MAX_LABEL(LABEL_MAX)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (name_if.sink),
    .out_chan (msg_if.source)
  );

  // query message predictor state
  logic        in_name = 1'b0;
  byte_t       label_buf [LABEL_MAX];
  int unsigned label_len = 0;
  logic        label_cut = 1'b0;

  msg_byte_t expected_q [$];
  byte_t     name_q [$];
  int        mismatches = 0;
  int        items_sent = 0;
  int        bytes_seen = 0;
  int        burst_left = 0;

  function automatic void push_msg(input byte_t b, input logic msg_end, input logic cut);
    msg_byte_t m;
    m.data      = b;
    m.msg_end   = msg_end;
    m.beat_last = 1'b0;
    m.cut       = cut;
    expected_q.push_back(m);
  endfunction

  // length byte then data; an empty label emits nothing
  function automatic void close_label();
    if (label_len != 0) begin
      push_msg(byte_t'(label_len), 1'b0, label_cut);
      for (int i = 0; i < int'(label_len); i++)
        push_msg(label_buf[i], 1'b0, label_cut);
    end
    label_len = 0;
    label_cut = 1'b0;
  endfunction

  function automatic void predict_beat(input byte_t ch, input logic fin,
                                       input logic [15:0] id);
    int        q_mark;
    msg_byte_t tail;
    q_mark = expected_q.size();
    if (!in_name) begin
      push_msg(id[15:8], 1'b0, 1'b0);
      push_msg(id[7:0], 1'b0, 1'b0);
      for (int i = 0; i < 10; i++)
        push_msg(HDR_TAIL[79-8*i -: 8], 1'b0, 1'b0);
      in_name   = 1'b1;
      label_len = 0;
      label_cut = 1'b0;
    end
    if (ch == DOT_CHAR) begin
      close_label();
    end else if (label_len < LABEL_MAX) begin
      label_buf[label_len] = ch;
      label_len++;
    end else begin
      label_cut = 1'b1;
    end
    if (fin) begin
      close_label();
      for (int i = 0; i < 5; i++)
        push_msg(QUESTION_TAIL[39-8*i -: 8], i == 4, 1'b0);
      in_name = 1'b0;
    end
    // flag the last byte this beat caused
    if (expected_q.size() > q_mark) begin
      tail = expected_q.pop_back();
      tail.beat_last = 1'b1;
      expected_q.push_back(tail);
    end
  endfunction

  function automatic void check_msg(input msg_byte_t got);
    msg_byte_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= SHOWN_MAX)
        $display("byte %0d: none expected, got data=%h end=%b run=%b ovf=%b",
                 bytes_seen, got.data, got.msg_end, got.beat_last, got.cut);
    end else begin
      want = expected_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= SHOWN_MAX)
          $display("byte %0d: expected data=%h end=%b run=%b ovf=%b, got data=%h end=%b run=%b ovf=%b",
                   bytes_seen, want.data, want.msg_end, want.beat_last, want.cut,
                   got.data, got.msg_end, got.beat_last, got.cut);
      end
    end
    bytes_seen++;
  endfunction

  task automatic send_char(input byte_t ch, input logic fin, input logic [15:0] id);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0)
        gap = $urandom_range(1, 12);
    end
    burst_left--;
    if (gap != 0) begin
      name_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    name_if.valid     <= 1'b1;
    name_if.name_byte <= ch;
    name_if.name_end  <= fin;
    name_if.query_id  <= id;
    @(posedge clk);
    while (!name_if.ready) @(posedge clk);
    predict_beat(ch, fin, id);
    items_sent++;
  endtask

  // drain name_q as one name; later beats carry junk ids that must be ignored
  task automatic send_name(input logic [15:0] id);
    int cnt;
    cnt = name_q.size();
    for (int i = 0; i < cnt; i++)
      send_char(name_q[i], i == cnt - 1, (i == 0) ? id : 16'($urandom));
    name_q.delete();
  endtask

  function automatic void add_text(input string s);
    for (int i = 0; i < s.len(); i++)
      name_q.push_back(byte_t'(s[i]));
  endfunction

  function automatic void add_label(input int len);
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 5))
        0:       name_q.push_back(8'h30 + byte_t'($urandom_range(0, 9)));
        1:       name_q.push_back(8'h2D);
        default: name_q.push_back(8'h61 + byte_t'($urandom_range(0, 25)));
      endcase
    end
  endfunction

  task automatic test_one_char_names();
    add_text("a");
    send_name(16'hFFFF);
    name_q.push_back(8'h00);
    send_name(16'h0000);
    name_q.push_back(8'hFF);
    send_name(16'h8001);
  endtask

  task automatic test_empty_labels();
    add_text(".a..b.");
    send_name(16'h1234);
    add_text(".");
    send_name(16'hABCD);
    add_text("x.");
    send_name(16'h00FF);
  endtask

  task automatic test_multi_label();
    add_text("ab.c-d9");
    send_name(16'h5A3C);
    name_q.push_back(8'h00);
    add_text(".");
    name_q.push_back(8'h7F);
    send_name(16'hC3A5);
  endtask

  task automatic test_long_labels();
    add_label(LABEL_MAX - 1);
    send_name(16'h0F0F);
    add_label(LABEL_MAX);
    send_name(16'hF0F0);
    add_label(LABEL_MAX + 1);
    send_name(16'h7FFE);
    // cut label followed by a normal one
    add_label(LABEL_MAX + 9);
    add_text(".z");
    send_name(16'h0101);
  endtask

  task automatic test_random_names();
    int nlab;
    int len;
    int pick;
    while (items_sent < ITEM_GOAL) begin
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 9) == 0) name_q.push_back(DOT_CHAR);
        nlab = $urandom_range(1, 4);
        for (int k = 0; k < nlab; k++) begin
          pick = $urandom_range(0, 19);
          if (pick < 14)      len = $urandom_range(1, 6);
          else if (pick < 18) len = $urandom_range(7, 20);
          else                len = $urandom_range(LABEL_MAX - 4, LABEL_MAX + 8);
          add_label(len);
          if (k != nlab - 1) begin
            name_q.push_back(DOT_CHAR);
            if ($urandom_range(0, 9) == 0) name_q.push_back(DOT_CHAR);
          end
        end
        if ($urandom_range(0, 7) == 0) name_q.push_back(DOT_CHAR);
      end else begin
        // noise: raw bytes with a fair share of dots
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++)
          name_q.push_back(($urandom_range(0, 5) == 0) ? DOT_CHAR
                                                       : byte_t'($urandom_range(0, 255)));
      end
      send_name(16'($urandom));
    end
  endtask

  // result sink: check accepted bytes, stall on a rotating pattern
  initial begin
    logic [7:0] ready_pat;
    int         pat_age;
    msg_byte_t  got;
    ready_pat = 8'hFF;
    pat_age   = 0;
    msg_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (msg_if.valid && msg_if.ready) begin
        got.data      = msg_if.packet_byte;
        got.msg_end   = msg_if.packet_end;
        got.beat_last = msg_if.run_end;
        got.cut       = msg_if.label_overflow;
        check_msg(got);
      end
      pat_age++;
      if (pat_age % 64 == 0)
        ready_pat = ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
      else
        ready_pat = {ready_pat[6:0], ready_pat[7]};
      msg_if.ready <= ready_pat[7];
    end
  end

  // watchdog: end the run if neither channel moves a beat for too long
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (name_if.valid && name_if.ready) || (msg_if.valid && msg_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_n             <= 1'b0;
    name_if.valid     <= 1'b0;
    name_if.name_byte <= 8'h00;
    name_if.name_end  <= 1'b0;
    name_if.query_id  <= 16'h0000;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_one_char_names();
    test_empty_labels();
    test_multi_label();
    test_long_labels();
    test_random_names();

    name_if.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    // hold to catch stray bytes
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_q.size() != 0) begin
      $display("%0d expected bytes never arrived", expected_q.size());
      mismatches += expected_q.size();
    end
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

/* files.f */
hdl/dqb_pkg.sv
hdl/dqb_if.sv
hdl/dqb_label_mem.sv
hdl/dns_query_builder.sv
tb/sv/tb.sv
